// ===== sv/rsq_pkg.sv =====
`default_nettype none
package rsq_pkg;

    localparam int SincosTableDepth = 1024;
    localparam int IdxW = $clog2(SincosTableDepth);
    localparam int QLen = SincosTableDepth / 4;
    localparam int QW = $clog2(QLen);
    localparam int PosW = 24;
    localparam int SizeW = 23;
    localparam int UvW = 16;

    localparam logic [1:0] CfgTexU0 = 2'd0;
    localparam logic [1:0] CfgTexV0 = 2'd1;
    localparam logic [1:0] CfgTexWidth = 2'd2;
    localparam logic [1:0] CfgTexHeight = 2'd3;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic [22:0] size_w;
        logic [22:0] size_h;
        logic [15:0] pivot_x;
        logic [15:0] pivot_y;
        logic signed [15:0] turn_angle;
        logic [31:0] src_u_pair;
        logic [31:0] src_v_pair;
        logic [1:0] flip_bits;
        logic [31:0] tint_rgba;
    } t_sprite;

    typedef struct packed {
        logic signed [23:0] vert_x;
        logic signed [23:0] vert_y;
        logic [15:0] vert_u;
        logic [15:0] vert_v;
        logic [31:0] vert_color;
        logic last_vertex;
    } t_vertex;

    typedef struct packed {
        logic [3:0] index;
        logic [15:0] data;
    } t_cfg;

    // Quarter-wave sine: Q30 argument, Q16 result capped at 1.0.
    function automatic logic signed [17:0] quarter_sin(input logic [30:0] t);
        logic [63:0] u;
        logic [63:0] p;
        logic [63:0] c [5];
        c[0] = 64'd1686629713; c[1] = 64'd693598671; c[2] = 64'd85569306;
        c[3] = 64'd5026994; c[4] = 64'd172272;
        u = ({33'd0, t} * {33'd0, t}) >> 30;
        p = c[4];
        for (int i = 3; i >= 0; i--) begin
            p = c[i] - ((u * p) >> 30);
        end
        p = ({33'd0, t} * p) >> 30;
        p = (p + 64'd8192) >> 14;
        if (p > 64'd65536) begin
            p = 64'd65536;
        end
        return signed'({1'b0, p[16:0]});
    endfunction

    // Quarter-wave table, 17 bits per entry, built at elaboration.
    function automatic logic [QLen*17-1:0] build_qtab();
        logic [QLen*17-1:0] tab;
        logic [30:0] t;
        logic signed [17:0] m;
        tab = '0;
        for (int j = 0; j < QLen; j++) begin
            t = 31'((64'(j) << 30) / QLen);
            m = quarter_sin(t);
            tab[j*17 +: 17] = m[16:0];
        end
        return tab;
    endfunction

    localparam logic [QLen*17-1:0] QTab = build_qtab();
    localparam logic [16:0] QsOne = 17'(quarter_sin(31'd1073741824));

    // Table entry k: sine of k/depth turns, Q16, mirrored from the quarter table.
    function automatic logic signed [17:0] sin_entry(input logic [IdxW-1:0] k);
        logic [1:0] quad;
        logic [QW-1:0] j;
        logic [QW-1:0] jm;
        logic [16:0] mag;
        quad = k[IdxW-1:IdxW-2];
        j = k[IdxW-3:0];
        jm = QW'(QLen - int'(j));
        if (quad[0]) begin
            mag = (j == '0) ? QsOne : QTab[int'(jm)*17 +: 17];
        end else begin
            mag = QTab[int'(j)*17 +: 17];
        end
        return quad[1] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
    endfunction

endpackage
`default_nettype wire

// ===== sv/rsq_if.sv =====
`default_nettype none
interface rsq_sprite_if;
    logic valid;
    logic ready;
    rsq_pkg::t_sprite data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface rsq_vertex_if;
    logic valid;
    logic ready;
    rsq_pkg::t_vertex data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface rsq_cfg_if;
    logic valid;
    logic ready;
    rsq_pkg::t_cfg data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/rsq_geom.sv =====
`default_nettype none
// Corner geometry: pivot multiply, table lookup, rotation multiply, sum.
// Four stages, each advancing on i_adv.
module rsq_geom (
    input  wire logic i_clk,
    input  wire logic i_adv,
    input  wire rsq_pkg::t_sprite i_spr,
    output rsq_pkg::t_sprite o_spr,
    output logic signed [25:0] o_x [4],
    output logic signed [25:0] o_y [4]
);
    import rsq_pkg::*;

    // stage 1: pivot products, table index
    t_sprite r_s1;
    logic [38:0] r_pwx, r_phy;
    logic [IdxW-1:0] r_k1;
    logic r_rot1;
    logic [15+IdxW+1:0] n_kfull;

    assign n_kfull = {1'b0, i_spr.turn_angle} * (IdxW+17)'(SincosTableDepth)
                     + (IdxW+17)'(32768);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1 <= i_spr;
            r_pwx <= i_spr.size_w * i_spr.pivot_x;
            r_phy <= i_spr.size_h * i_spr.pivot_y;
            r_k1 <= n_kfull[IdxW+15:16];
            r_rot1 <= i_spr.turn_angle != 16'sd0;
        end
    end

    // stage 2: corners, sine and cosine
    t_sprite r_s2;
    logic signed [24:0] r_cx, r_cy, r_ax, r_ay;
    logic signed [17:0] r_sn, r_cs;
    logic r_rot2;
    logic [39:0] n_cx, n_cy;

    assign n_cx = {1'b0, r_pwx} + 40'd32768;
    assign n_cy = {1'b0, r_phy} + 40'd32768;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s2 <= r_s1;
            r_cx <= signed'({2'b0, n_cx[38:16]});
            r_cy <= signed'({2'b0, n_cy[38:16]});
            r_ax <= signed'({2'b0, r_s1.size_w}) - signed'({2'b0, n_cx[38:16]});
            r_ay <= signed'({2'b0, r_s1.size_h}) - signed'({2'b0, n_cy[38:16]});
            r_sn <= sin_entry(r_k1);
            r_cs <= sin_entry(IdxW'(r_k1 + IdxW'(SincosTableDepth / 4)));
            r_rot2 <= r_rot1;
        end
    end

    // stage 3: rotation products for c1..c3
    t_sprite r_s3;
    logic signed [24:0] r_x3 [3], r_y3 [3];
    logic signed [43:0] r_cxp [3], r_syp [3], r_sxp [3], r_cyp [3];
    logic r_rot3;
    logic signed [24:0] w_x [3], w_y [3];

    assign w_x[0] = -r_cx; assign w_y[0] = -r_cy;
    assign w_x[1] = -r_cx; assign w_y[1] = r_ay;
    assign w_x[2] = r_ax;  assign w_y[2] = r_ay;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s3 <= r_s2;
            r_rot3 <= r_rot2;
            for (int i = 0; i < 3; i++) begin
                r_x3[i] <= w_x[i];
                r_y3[i] <= w_y[i];
                r_cxp[i] <= r_cs * w_x[i];
                r_syp[i] <= r_sn * w_y[i];
                r_sxp[i] <= r_sn * w_x[i];
                r_cyp[i] <= r_cs * w_y[i];
            end
        end
    end

    function automatic logic signed [25:0] rnd16(input logic signed [44:0] v);
        logic [44:0] a;
        a = v[44] ? 45'(-v) : 45'(v);
        a = (a + 45'd32768) >> 16;
        return v[44] ? -signed'(a[25:0]) : signed'(a[25:0]);
    endfunction

    // stage 4: round, fourth corner
    logic signed [25:0] n_x [3], n_y [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_rot3) begin
                n_x[i] = rnd16(45'(r_cxp[i]) - 45'(r_syp[i]));
                n_y[i] = rnd16(45'(r_sxp[i]) + 45'(r_cyp[i]));
            end else begin
                n_x[i] = 26'(r_x3[i]);
                n_y[i] = 26'(r_y3[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_spr <= r_s3;
            for (int i = 0; i < 3; i++) begin
                o_x[i] <= n_x[i];
                o_y[i] <= n_y[i];
            end
            o_x[3] <= n_x[0] + (n_x[2] - n_x[1]);
            o_y[3] <= n_y[2] - (n_y[1] - n_y[0]);
        end
    end
endmodule
`default_nettype wire

// ===== sv/rsq_emit.sv =====
`default_nettype none
// Vertex sequencer: holds one quad, hands out six beats c1,c2,c3,c1,c3,c4.
module rsq_emit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_load,
    input  wire rsq_pkg::t_sprite i_spr,
    input  wire logic signed [25:0] i_x [4],
    input  wire logic signed [25:0] i_y [4],
    input  wire logic [15:0] i_tex [4],
    output logic o_busy,
    output logic o_last,
    rsq_vertex_if.source o_vtx
);
    import rsq_pkg::*;

    logic [2:0] r_cnt;
    logic r_busy;
    t_sprite r_spr;
    logic signed [25:0] r_x [4], r_y [4];
    logic [15:0] r_tex [4];
    logic [1:0] w_c;
    logic [15:0] w_u, w_v;
    logic [UvW:0] n_ru, n_rv;
    logic signed [26:0] n_px, n_py;
    logic [31:0] w_mu, w_mv;

    always_comb begin
        case (r_cnt)
            3'd0: w_c = 2'd0;
            3'd1: w_c = 2'd1;
            3'd2: w_c = 2'd2;
            3'd3: w_c = 2'd0;
            3'd4: w_c = 2'd2;
            default: w_c = 2'd3;
        endcase
        w_u = (w_c == 2'd0 || w_c == 2'd1)
              ? (r_spr.flip_bits[0] ? r_spr.src_u_pair[15:0] : r_spr.src_u_pair[31:16])
              : (r_spr.flip_bits[0] ? r_spr.src_u_pair[31:16] : r_spr.src_u_pair[15:0]);
        w_v = (w_c == 2'd0 || w_c == 2'd3)
              ? (r_spr.flip_bits[1] ? r_spr.src_v_pair[15:0] : r_spr.src_v_pair[31:16])
              : (r_spr.flip_bits[1] ? r_spr.src_v_pair[31:16] : r_spr.src_v_pair[15:0]);
        w_mu = w_u * r_tex[CfgTexWidth] + 32'd32768;
        w_mv = w_v * r_tex[CfgTexHeight] + 32'd32768;
        n_ru = {1'b0, w_mu[31:16]} + {1'b0, r_tex[CfgTexU0]};
        n_rv = {1'b0, w_mv[31:16]} + {1'b0, r_tex[CfgTexV0]};
        n_px = 27'(r_x[w_c]) + 27'(r_spr.pos_x);
        n_py = 27'(r_y[w_c]) + 27'(r_spr.pos_y);
    end

    function automatic logic signed [23:0] sat(input logic signed [26:0] v);
        if (v > 27'sd8388607) return 24'sh7FFFFF;
        if (v < -27'sd8388608) return 24'sh800000;
        return v[23:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_spr <= i_spr;
            r_x <= i_x;
            r_y <= i_y;
            r_tex <= i_tex;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= 3'd0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_cnt <= 3'd0;
        end else if (r_busy && o_vtx.ready) begin
            if (r_cnt == 3'd5) begin
                r_busy <= 1'b0;
                r_cnt <= 3'd0;
            end else begin
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_last = r_busy && o_vtx.ready && r_cnt == 3'd5;
    assign o_vtx.valid = r_busy;
    assign o_vtx.data.vert_x = sat(n_px);
    assign o_vtx.data.vert_y = sat(n_py);
    assign o_vtx.data.vert_u = n_ru[UvW] ? 16'hFFFF : n_ru[15:0];
    assign o_vtx.data.vert_v = n_rv[UvW] ? 16'hFFFF : n_rv[15:0];
    assign o_vtx.data.vert_color = r_spr.tint_rgba;
    assign o_vtx.data.last_vertex = r_cnt == 3'd5;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd5) else $error("vertex count out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !o_vtx.ready && !i_load |=> $stable(r_cnt))
        else $error("count moved under stall");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> !r_busy || o_last) else $error("quad overwritten");
endmodule
`default_nettype wire

// ===== sv/rotated_sprite_quad_setup.sv =====
`default_nettype none
// Channel   Dir  Payload                         Beat
// i_spr     in   t_sprite (sprite request)       one per sprite
// o_vtx     out  t_vertex (one vertex)           six per sprite
// i_cfg     in   t_cfg (index, 16-bit data)      one per register write
//
// A sprite passes a 4-stage geometry pipeline (pivot multiply, sin/cos
// table, rotation multiply, round) and then the vertex sequencer, which
// emits six beats, one a cycle while o_vtx is ready; the sequencer sets the
// sprite rate, loading a new quad when idle or on the last beat of the old.
// Reset (sync, active low) clears valid bits and restores texture region.
// Stalls freeze the pipeline; nothing is dropped or repeated.
module rotated_sprite_quad_setup (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rsq_sprite_if.sink i_spr,
    rsq_cfg_if.sink i_cfg,
    rsq_vertex_if.source o_vtx
);
    import rsq_pkg::*;

    logic [15:0] r_tex [4];
    logic [3:0] r_vld;
    logic w_adv, w_load, w_busy, w_last;
    t_sprite w_gspr;
    logic signed [25:0] w_x [4], w_y [4];

    // the sequencer is free when idle or on its last accepted beat
    assign w_load = r_vld[3] && (!w_busy || w_last);
    assign w_adv = !r_vld[3] || w_load;
    assign i_spr.ready = w_adv;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_tex[CfgTexU0] <= 16'd0;
            r_tex[CfgTexV0] <= 16'd0;
            r_tex[CfgTexWidth] <= 16'hFFFF;
            r_tex[CfgTexHeight] <= 16'hFFFF;
        end else begin
            if (w_adv) r_vld <= {r_vld[2:0], i_spr.valid};
            if (i_cfg.valid && i_cfg.data.index[3:2] == 2'b00) begin
                r_tex[i_cfg.data.index[1:0]] <= i_cfg.data.data;
            end
        end
    end

    rsq_geom u_geom (
        .i_clk(i_clk), .i_adv(w_adv), .i_spr(i_spr.data),
        .o_spr(w_gspr), .o_x(w_x), .o_y(w_y)
    );

    rsq_emit u_emit (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(w_load), .i_spr(w_gspr),
        .i_x(w_x), .i_y(w_y), .i_tex(r_tex), .o_busy(w_busy), .o_last(w_last),
        .o_vtx(o_vtx)
    );

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld)) else $error("valid bits moved in stall");
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> w_busy) else $error("load did not start quad");
    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vtx.valid |-> w_busy) else $error("vertex without quad");
endmodule
`default_nettype wire
